// ===== rtl/vic_pkg.sv =====
// ----------------------------------------------------------------------------
// vic_pkg - shared definitions of the virtual instruction clock
// Field widths, stream packing offsets, register and status codes, and the
// sizes of the serial multiplier and divider.
// ----------------------------------------------------------------------------
package vic_pkg;

  // Fixed-point fraction of the drift divisor
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int MODE_W    = 2;
  localparam int ICOUNT_W  = 64;
  localparam int TSEC_W    = 34;
  localparam int TNS_W     = 30;
  localparam int SEC_W     = 35;
  localparam int NS_W      = 30;
  localparam int STATUS_W  = 2;
  localparam int NPI_W     = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Stream packing, lowest field first
  localparam int IN_TSEC_LSB    = ICOUNT_W;
  localparam int IN_TNS_LSB     = IN_TSEC_LSB + TSEC_W;
  localparam int IN_TDATA_W     = IN_TNS_LSB + TNS_W;
  localparam int OUT_NS_LSB     = SEC_W;
  localparam int OUT_TICKS_LSB  = OUT_NS_LSB + NS_W;
  localparam int OUT_STATUS_LSB = OUT_TICKS_LSB + ICOUNT_W;
  localparam int OUT_USED_W     = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_USED_W;

  // Serial arithmetic units
  localparam int MUL_XW  = 64;
  localparam int MUL_MW  = 32;
  localparam int MUL_W   = MUL_XW + MUL_MW;
  localparam int MUL_CW  = $clog2(MUL_MW);
  localparam int DIV_W   = 96;
  localparam int DIV_DW  = 32;
  localparam int DIV_CW  = $clog2(DIV_W);

  localparam logic [DIV_DW-1:0] NS_PER_SEC  = 32'd1000000000;
  localparam int                SLOW_FACTOR = 30;
  localparam int                STEP30_W    = CFG_W + 5;

  // Register reset values
  localparam logic [NPI_W-1:0] NPI_RST   = 16'd1;
  localparam logic [CFG_W-1:0] DRIFT_RST = 32'd65536;
  localparam logic [CFG_W-1:0] STEP_RST  = 32'd1;
  localparam logic [CFG_W-1:0] LIMIT_RST = 32'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK = 2'd0,
    MODE_READ = 2'd1,
    MODE_SET  = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BACKWARD = 2'd1,
    STATUS_PAST     = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NS_PER_INSN = 2'd0,
    REG_DRIFT       = 2'd1,
    REG_OFFSET_STEP = 2'd2,
    REG_SLOW_LIMIT  = 2'd3
  } cfg_idx_e;

endpackage

// ===== rtl/virtual_instruction_clock.sv =====
// Flow: each beat runs the serial multiplier, then the serial divider twice (scale
// by drift, split into s and ns); a set that moves the clock then runs the gap
// multiply, count multiply and count divide and repeats the scale and split
// (32-step serial multiplier, 96-step serial divider). The next beat is taken
// once the previous result sits in the output register.
// Reset: registers return to their defaults, all counts and offsets clear.
// ----------------------------------------------------------------------------
// virtual_instruction_clock - instruction-count driven virtual time
// Ticks set a base count or extend the offset, sets ahead extend it too; every
// beat reports virtual time (base + offset) * ns_per_instruction / drift in s, ns
// ----------------------------------------------------------------------------
module virtual_instruction_clock (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [vic_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [vic_pkg::CFG_W-1:0]         cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [63:0] instruction_count, [97:64] target_seconds, [127:98] target_nanoseconds
  input  logic [vic_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] mode
  input  logic [vic_pkg::MODE_W-1:0]        s_axis_tuser,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [34:0] seconds, [64:35] nanoseconds, [128:65] capture_ticks,
  // [130:129] status, [135:131] zero
  output logic [vic_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_NOW_MUL = 8'b0000_0010,
    ST_NOW_DIV = 8'b0000_0100,
    ST_SPLIT   = 8'b0000_1000,
    ST_GAP_MUL = 8'b0001_0000,
    ST_SET_MUL = 8'b0010_0000,
    ST_SET_DIV = 8'b0100_0000,
    ST_OUT     = 8'b1000_0000
  } state_e;

  localparam int HI_LSB = vic_pkg::ICOUNT_W + vic_pkg::FRAC_BITS;

  state_e state_q, state_d;

  // configuration
  logic [vic_pkg::NPI_W-1:0] npi_q, npi_d;
  logic [vic_pkg::CFG_W-1:0] drift_q, drift_d;
  logic [vic_pkg::CFG_W-1:0] step_q, step_d;
  logic [vic_pkg::CFG_W-1:0] limit_q, limit_d;

  // clock state
  logic [vic_pkg::ICOUNT_W-1:0] tick_q, tick_d;
  logic [vic_pkg::ICOUNT_W-1:0] base_q, base_d;
  logic [vic_pkg::ICOUNT_W-1:0] off_q, off_d;
  logic [vic_pkg::CFG_W-1:0]    run_q, run_d;

  // item in flight
  logic                          pre_q, pre_d;
  logic [vic_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [vic_pkg::TSEC_W-1:0]    ts_q, ts_d;
  logic [vic_pkg::TNS_W-1:0]     tn_q, tn_d;
  logic [vic_pkg::ICOUNT_W-1:0]  n_q, n_d;

  // output register
  logic                          m_valid_q, m_valid_d;
  logic [vic_pkg::SEC_W-1:0]     out_sec_q, out_sec_d;
  logic [vic_pkg::NS_W-1:0]      out_ns_q, out_ns_d;
  logic [vic_pkg::ICOUNT_W-1:0]  out_ticks_q, out_ticks_d;
  logic [vic_pkg::STATUS_W-1:0]  out_status_q, out_status_d;

  // unit control
  logic mul_go_q, mul_go_d;
  logic div_go_q, div_go_d;

  logic                        mul_done;
  logic [vic_pkg::MUL_XW-1:0]  mul_x;
  logic [vic_pkg::MUL_MW-1:0]  mul_m;
  logic [vic_pkg::MUL_W-1:0]   mul_prod;
  logic                        div_done;
  logic [vic_pkg::DIV_W-1:0]   div_dvd;
  logic [vic_pkg::DIV_DW-1:0]  div_dvs;
  logic [vic_pkg::DIV_W-1:0]   div_quot;
  logic [vic_pkg::DIV_DW-1:0]  div_rem;

  logic [vic_pkg::ICOUNT_W-1:0] in_icount;
  logic                         accept;
  logic [vic_pkg::CFG_W-1:0]    run_inc;
  logic [vic_pkg::STEP30_W-1:0] step30;
  logic [vic_pkg::ICOUNT_W-1:0] now_ns;
  logic [vic_pkg::ICOUNT_W-1:0] set_cnt;
  logic [vic_pkg::SEC_W-1:0]    cur_s;
  logic [vic_pkg::NS_W-1:0]     cur_n;
  logic [vic_pkg::SEC_W-1:0]    tgt_s;
  logic                         later;
  logic                         earlier;

  assign in_icount = s_axis_tdata[vic_pkg::ICOUNT_W-1:0];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign run_inc   = (run_q == '1) ? run_q : run_q + 1'b1;
  assign step30    = vic_pkg::STEP30_W'(step_q) * vic_pkg::STEP30_W'(vic_pkg::SLOW_FACTOR);

  // saturate quotients that need more than 64 bits
  assign now_ns  = (|div_quot[vic_pkg::DIV_W-1:vic_pkg::ICOUNT_W]) ? '1
                 : div_quot[vic_pkg::ICOUNT_W-1:0];
  assign set_cnt = (|div_quot[vic_pkg::DIV_W-1:HI_LSB]) ? '1
                 : div_quot[HI_LSB-1:vic_pkg::FRAC_BITS];

  assign cur_s   = div_quot[vic_pkg::SEC_W-1:0];
  assign cur_n   = div_rem[vic_pkg::NS_W-1:0];
  assign tgt_s   = vic_pkg::SEC_W'(ts_q);
  assign later   = (tgt_s > cur_s) || ((tgt_s == cur_s) && (tn_q > cur_n));
  assign earlier = (tgt_s < cur_s) || ((tgt_s == cur_s) && (tn_q < cur_n));

  // operand select; units latch them in the first cycle of each state
  always_comb begin
    mul_x   = '0;
    mul_m   = '0;
    div_dvd = '0;
    div_dvs = '0;
    case (state_q)
      ST_NOW_MUL: begin
        mul_x = base_q + off_q;
        mul_m = vic_pkg::MUL_MW'(npi_q);
      end
      ST_GAP_MUL: begin
        mul_x = vic_pkg::MUL_XW'(ts_q) - vic_pkg::MUL_XW'(cur_s);
        mul_m = vic_pkg::NS_PER_SEC;
      end
      ST_SET_MUL: begin
        mul_x = n_q;
        mul_m = drift_q;
      end
      ST_NOW_DIV: begin
        div_dvd = vic_pkg::DIV_W'({mul_prod[vic_pkg::ICOUNT_W-1:0],
                                   {vic_pkg::FRAC_BITS{1'b0}}});
        div_dvs = drift_q;
      end
      ST_SPLIT: begin
        div_dvd = vic_pkg::DIV_W'(now_ns);
        div_dvs = vic_pkg::NS_PER_SEC;
      end
      ST_SET_DIV: begin
        div_dvd = mul_prod;
        div_dvs = (npi_q == '0) ? vic_pkg::DIV_DW'(1) : vic_pkg::DIV_DW'(npi_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    npi_d        = npi_q;
    drift_d      = drift_q;
    step_d       = step_q;
    limit_d      = limit_q;
    tick_d       = tick_q;
    base_d       = base_q;
    off_d        = off_q;
    run_d        = run_q;
    pre_d        = pre_q;
    status_d     = status_q;
    ts_d         = ts_q;
    tn_d         = tn_q;
    n_d          = n_q;
    m_valid_d    = m_valid_q;
    out_sec_d    = out_sec_q;
    out_ns_d     = out_ns_q;
    out_ticks_d  = out_ticks_q;
    out_status_d = out_status_q;
    mul_go_d     = 1'b0;
    div_go_d     = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        vic_pkg::REG_NS_PER_INSN: npi_d   = cfg_data_i[vic_pkg::NPI_W-1:0];
        vic_pkg::REG_DRIFT:       drift_d = cfg_data_i;
        vic_pkg::REG_OFFSET_STEP: step_d  = cfg_data_i;
        vic_pkg::REG_SLOW_LIMIT:  limit_d = cfg_data_i;
        default: begin
        end
      endcase
    end

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ts_d     = s_axis_tdata[vic_pkg::IN_TSEC_LSB +: vic_pkg::TSEC_W];
          tn_d     = s_axis_tdata[vic_pkg::IN_TNS_LSB +: vic_pkg::TNS_W];
          pre_d    = (s_axis_tuser == vic_pkg::MODE_SET);
          status_d = vic_pkg::STATUS_OK;
          if (s_axis_tuser == vic_pkg::MODE_TICK) begin
            if ((in_icount != '0) && (in_icount < base_q)) begin
              status_d = vic_pkg::STATUS_BACKWARD;
            end else begin
              tick_d = tick_q + 1'b1;
              if (in_icount != '0) begin
                base_d = in_icount;
                run_d  = '0;
              end else begin
                run_d = run_inc;
                if (run_inc < limit_q) begin
                  off_d = off_q + vic_pkg::ICOUNT_W'(step_q);
                end else begin
                  off_d = off_q + vic_pkg::ICOUNT_W'(step30);
                end
              end
            end
          end
          mul_go_d = 1'b1;
          state_d  = ST_NOW_MUL;
        end
      end
      ST_NOW_MUL: begin
        if (mul_done) begin
          div_go_d = 1'b1;
          state_d  = ST_NOW_DIV;
        end
      end
      ST_NOW_DIV: begin
        if (div_done) begin
          div_go_d = 1'b1;
          state_d  = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (div_done) begin
          if (pre_q && later) begin
            mul_go_d = 1'b1;
            state_d  = ST_GAP_MUL;
          end else begin
            // past target leaves the clock alone; equal target is a no-op
            if (pre_q && earlier) begin
              status_d = vic_pkg::STATUS_PAST;
            end
            state_d = ST_OUT;
          end
        end
      end
      ST_GAP_MUL: begin
        if (mul_done) begin
          n_d = mul_prod[vic_pkg::ICOUNT_W-1:0] + vic_pkg::ICOUNT_W'(tn_q)
              - vic_pkg::ICOUNT_W'(cur_n) + vic_pkg::ICOUNT_W'(npi_q);
          mul_go_d = 1'b1;
          state_d  = ST_SET_MUL;
        end
      end
      ST_SET_MUL: begin
        if (mul_done) begin
          div_go_d = 1'b1;
          state_d  = ST_SET_DIV;
        end
      end
      ST_SET_DIV: begin
        if (div_done) begin
          off_d    = off_q + set_cnt;
          pre_d    = 1'b0;
          mul_go_d = 1'b1;
          state_d  = ST_NOW_MUL;
        end
      end
      ST_OUT: begin
        // hold the split result until the output register frees up
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d    = 1'b1;
          out_sec_d    = cur_s;
          out_ns_d     = cur_n;
          out_ticks_d  = tick_q;
          out_status_d = status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      npi_q     <= vic_pkg::NPI_RST;
      drift_q   <= vic_pkg::DRIFT_RST;
      step_q    <= vic_pkg::STEP_RST;
      limit_q   <= vic_pkg::LIMIT_RST;
      tick_q    <= '0;
      base_q    <= '0;
      off_q     <= '0;
      run_q     <= '0;
      pre_q     <= 1'b0;
      status_q  <= vic_pkg::STATUS_OK;
      m_valid_q <= 1'b0;
      mul_go_q  <= 1'b0;
      div_go_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      npi_q     <= npi_d;
      drift_q   <= drift_d;
      step_q    <= step_d;
      limit_q   <= limit_d;
      tick_q    <= tick_d;
      base_q    <= base_d;
      off_q     <= off_d;
      run_q     <= run_d;
      pre_q     <= pre_d;
      status_q  <= status_d;
      m_valid_q <= m_valid_d;
      mul_go_q  <= mul_go_d;
      div_go_q  <= div_go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q         <= ts_d;
    tn_q         <= tn_d;
    n_q          <= n_d;
    out_sec_q    <= out_sec_d;
    out_ns_q     <= out_ns_d;
    out_ticks_q  <= out_ticks_d;
    out_status_q <= out_status_d;
  end

  vic_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .x_i     (mul_x),
    .m_i     (mul_m),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  vic_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{vic_pkg::OUT_PAD_W{1'b0}}, out_status_q, out_ticks_q,
                          out_ns_q, out_sec_q};

endmodule

// ===== rtl/vic_serial_mul.sv =====
// ----------------------------------------------------------------------------
// vic_serial_mul - bit-serial shift-add multiplier
// Multiplies a 64-bit operand by a 32-bit operand, one multiplier bit per
// cycle, most significant bit first; full 96-bit product.
// ----------------------------------------------------------------------------
module vic_serial_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vic_pkg::MUL_XW-1:0]  x_i,
  input  logic [vic_pkg::MUL_MW-1:0]  m_i,
  output logic                        done_o,
  output logic [vic_pkg::MUL_W-1:0]   prod_o
);

  logic [vic_pkg::MUL_W-1:0]  acc_q, acc_d;
  logic [vic_pkg::MUL_XW-1:0] x_q, x_d;
  logic [vic_pkg::MUL_MW-1:0] m_q, m_d;
  logic [vic_pkg::MUL_CW-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    x_d    = x_q;
    m_d    = m_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      x_d    = x_i;
      m_d    = m_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[vic_pkg::MUL_W-2:0], 1'b0}
            + (m_q[vic_pkg::MUL_MW-1] ? vic_pkg::MUL_W'(x_q) : '0);
      m_d   = {m_q[vic_pkg::MUL_MW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == vic_pkg::MUL_CW'(vic_pkg::MUL_MW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    m_q   <= m_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/vic_serial_div.sv =====
// ----------------------------------------------------------------------------
// vic_serial_div - bit-serial restoring divider
// Divides a 96-bit dividend by a 32-bit divisor, one quotient bit per cycle.
// The dividend register shifts out at the top while quotient bits enter below.
// ----------------------------------------------------------------------------
module vic_serial_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vic_pkg::DIV_W-1:0]   dividend_i,
  input  logic [vic_pkg::DIV_DW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [vic_pkg::DIV_W-1:0]   quot_o,
  output logic [vic_pkg::DIV_DW-1:0]  rem_o
);

  logic [vic_pkg::DIV_W-1:0]  dq_q, dq_d;
  logic [vic_pkg::DIV_DW-1:0] rem_q, rem_d;
  logic [vic_pkg::DIV_DW-1:0] dvs_q, dvs_d;
  logic [vic_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [vic_pkg::DIV_DW:0]   trial;
  logic [vic_pkg::DIV_DW:0]   diff;
  logic                       fits;

  assign trial = {rem_q, dq_q[vic_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // a zero divisor yields an all-ones quotient; callers saturate on it
      rem_d = fits ? diff[vic_pkg::DIV_DW-1:0] : trial[vic_pkg::DIV_DW-1:0];
      dq_d  = {dq_q[vic_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == vic_pkg::DIV_CW'(vic_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/vic_checker.sv =====
// ----------------------------------------------------------------------------
// vic_checker - port-level checks of the virtual instruction clock
// Watches the stream ports for result stability, one-beat-at-a-time intake
// and well-formed result fields.
// ----------------------------------------------------------------------------
module vic_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [vic_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  logic [vic_pkg::STATUS_W-1:0] out_status;
  logic [vic_pkg::NS_W-1:0]     out_ns;

  assign out_status = m_axis_tdata[vic_pkg::OUT_STATUS_LSB +: vic_pkg::STATUS_W];
  assign out_ns     = m_axis_tdata[vic_pkg::OUT_NS_LSB +: vic_pkg::NS_W];

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // the serial datapath takes one beat and then works on it
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after a beat");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_status == vic_pkg::STATUS_OK ||
                       out_status == vic_pkg::STATUS_BACKWARD ||
                       out_status == vic_pkg::STATUS_PAST))
    else $error("undefined status on result");

  a_ns_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (vic_pkg::DIV_DW'(out_ns) < vic_pkg::NS_PER_SEC))
    else $error("nanoseconds out of range");

endmodule

bind virtual_instruction_clock vic_checker u_vic_checker (.*);

// ===== dv/virtual_instruction_clock_tb.sv =====
// ----------------------------------------------------------------------------
// virtual_instruction_clock_tb - self-checking bench for the virtual clock
// Sends tick, read and set beats into the input stream. The source leaves
// random gaps between beats and the sink stalls at random. A local model of
// the clock state and registers predicts each result, and every output beat
// is compared with its prediction field by field.
// ----------------------------------------------------------------------------
module virtual_instruction_clock_tb;
  import vic_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;   // unassigned code, reads
  localparam logic [63:0]       SEC_NS       = {32'd0, NS_PER_SEC};
  localparam int                MAX_HOLD     = 18;
  localparam int                REPORT_LIMIT = 10;
  localparam int                DRAIN_CYCLES = 700;
  localparam int                PHASES       = 8;
  localparam int                PHASE_BEATS  = 142;

  typedef struct packed {
    logic [SEC_W-1:0]    sec;
    logic [NS_W-1:0]     nsec;
    logic [ICOUNT_W-1:0] ticks;
    logic [STATUS_W-1:0] status;
  } vtime_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [MODE_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // local copy of the registers and the clock state
  logic [63:0] npi        = {48'd0, NPI_RST};
  logic [63:0] drift      = {32'd0, DRIFT_RST};
  logic [63:0] offset_inc = {32'd0, STEP_RST};
  logic [63:0] slow_limit = {32'd0, LIMIT_RST};
  logic [63:0] tick_total   = '0;
  logic [63:0] base_count   = '0;
  logic [63:0] count_offset = '0;
  logic [63:0] unknown_run  = '0;

  vtime_t pending_times[$];
  int     failures     = 0;
  int     beats_sent   = 0;
  int     results_seen = 0;
  int     reg_settings = 0;
  bit     source_rush  = 1'b0;
  bit     sink_rush    = 1'b0;

  virtual_instruction_clock u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("virtual_instruction_clock: mismatch");
    $finish;
  end

  function automatic logic [63:0] any_count();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TSEC_W-1:0] any_seconds();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TSEC_W-1:0];
  endfunction

  function automatic logic [TNS_W-1:0] any_nanos();
    logic [31:0] r;
    r = $urandom;
    return r[TNS_W-1:0];
  endfunction

  // (base + offset) * ns_per_instruction / drift, saturated at all ones
  function automatic logic [63:0] virtual_ns();
    logic [63:0]            raw;
    logic [64+FRAC_BITS-1:0] q;
    raw = (base_count + count_offset) * npi;
    if (drift == 64'd0) return '1;
    q = {raw, {FRAC_BITS{1'b0}}} / drift;
    if (q[64+FRAC_BITS-1:64] != '0) return '1;
    return q[63:0];
  endfunction

  // instructions that cover a forward jump of gap ns, computed exactly
  function automatic logic [63:0] gap_to_count(input logic [63:0] gap);
    logic [63:0]  divisor, n, q, r;
    logic [127:0] acc;
    divisor = (npi == 64'd0) ? 64'd1 : npi;
    n = gap + npi;
    q = n / divisor;
    r = n % divisor;
    acc = {64'd0, q} * {64'd0, drift} + ({64'd0, r} * {64'd0, drift}) / {64'd0, divisor};
    if (acc[127:64+FRAC_BITS] != '0) return '1;
    return acc[64+FRAC_BITS-1:FRAC_BITS];
  endfunction

  function automatic vtime_t advance_clock(input logic [MODE_W-1:0] mode,
                                           input logic [ICOUNT_W-1:0] icount,
                                           input logic [TSEC_W-1:0] ts,
                                           input logic [TNS_W-1:0] tn);
    vtime_t      r;
    logic [63:0] cur, cs, cn, ts64, tn64, gap;
    r.status = STATUS_OK;
    if (mode == MODE_TICK) begin
      if (icount != 64'd0 && icount < base_count) begin
        r.status = STATUS_BACKWARD;
      end else begin
        tick_total = tick_total + 64'd1;
        if (icount != 64'd0) begin
          base_count  = icount;
          unknown_run = '0;
        end else begin
          if (unknown_run != 64'hFFFF_FFFF) unknown_run = unknown_run + 64'd1;
          if (unknown_run < slow_limit) count_offset = count_offset + offset_inc;
          else count_offset = count_offset + offset_inc * SLOW_FACTOR;
        end
      end
    end else if (mode == MODE_SET) begin
      cur  = virtual_ns();
      cs   = cur / SEC_NS;
      cn   = cur % SEC_NS;
      ts64 = {30'd0, ts};
      tn64 = {34'd0, tn};
      if (ts64 < cs || (ts64 == cs && tn64 < cn)) begin
        r.status = STATUS_PAST;
      end else if (ts64 > cs || tn64 > cn) begin
        gap = (ts64 - cs) * SEC_NS + tn64 - cn;
        count_offset = count_offset + gap_to_count(gap);
      end
    end
    cur     = virtual_ns();
    cs      = cur / SEC_NS;
    cn      = cur % SEC_NS;
    r.sec   = cs[SEC_W-1:0];
    r.nsec  = cn[NS_W-1:0];
    r.ticks = tick_total;
    return r;
  endfunction

  // call at a rising edge; returns at the edge that took the beat
  task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [63:0] icount,
                           input logic [TSEC_W-1:0] ts, input logic [TNS_W-1:0] tn);
    int hold;
    if ($urandom_range(0, 39) == 0) source_rush = !source_rush;
    hold = source_rush ? 0 : $urandom_range(0, MAX_HOLD);
    if (hold > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (hold) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tn, ts, icount};
    s_axis_tuser  <= mode;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    pending_times.push_back(advance_clock(mode, icount, ts, tn));
    beats_sent++;
  endtask

  task automatic send_set_at(input logic [63:0] t_ns);
    logic [63:0] s, n;
    s = t_ns / SEC_NS;
    n = t_ns % SEC_NS;
    send_beat(MODE_SET, any_count(), s[TSEC_W-1:0], n[TNS_W-1:0]);
  endtask

  // drain the block, then write all four registers
  task automatic program_regs(input logic [CFG_W-1:0] npi_word, drift_word,
                              step_word, limit_word);
    cfg_idx_e         order [4];
    logic [CFG_W-1:0] words [4];
    order = '{REG_NS_PER_INSN, REG_DRIFT, REG_OFFSET_STEP, REG_SLOW_LIMIT};
    words = '{npi_word, drift_word, step_word, limit_word};
    s_axis_tvalid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= order[i];
      cfg_data_i <= words[i];
      @(posedge clk_i);
      case (order[i])
        REG_NS_PER_INSN: npi        = {48'd0, words[i][NPI_W-1:0]};
        REG_DRIFT:       drift      = {32'd0, words[i]};
        REG_OFFSET_STEP: offset_inc = {32'd0, words[i]};
        REG_SLOW_LIMIT:  slow_limit = {32'd0, words[i]};
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    reg_settings++;
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] beat);
    vtime_t want, got;
    got.sec    = beat[SEC_W-1:0];
    got.nsec   = beat[OUT_NS_LSB +: NS_W];
    got.ticks  = beat[OUT_TICKS_LSB +: ICOUNT_W];
    got.status = beat[OUT_STATUS_LSB +: STATUS_W];
    results_seen++;
    if (pending_times.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("result %0d with nothing outstanding: s=%0d ns=%0d ticks=%0d status=%0d",
                 results_seen, got.sec, got.nsec, got.ticks, got.status);
    end else begin
      want = pending_times.pop_front();
      if (got.sec != want.sec || got.nsec != want.nsec ||
          got.ticks != want.ticks || got.status != want.status) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("result %0d expected s=%0d ns=%0d ticks=%0d status=%0d",
                   results_seen, want.sec, want.nsec, want.ticks, want.status);
          $display("result %0d actual   s=%0d ns=%0d ticks=%0d status=%0d",
                   results_seen, got.sec, got.nsec, got.ticks, got.status);
        end
      end
    end
  endtask

  initial begin : sink
    int                     stall;
    logic [OUT_TDATA_W-1:0] beat;
    forever begin
      if ($urandom_range(0, 39) == 0) sink_rush = !sink_rush;
      stall = sink_rush ? 0 : $urandom_range(0, MAX_HOLD);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      beat = m_axis_tdata;
      @(posedge clk_i);
      check_result(beat);
    end
  end

  task automatic test_reset_state();
    send_beat(MODE_READ, 64'd0, '0, '0);
    send_beat(MODE_TICK, 64'd1_000_000_000, any_seconds(), any_nanos());
    send_beat(MODE_TICK, 64'd5, any_seconds(), any_nanos());
  endtask

  task automatic test_tick_rules();
    program_regs(32'd1, 32'd65536, 32'd7, 32'd2);
    // from the second unknown tick on, the run reaches the limit of two
    repeat (3) send_beat(MODE_TICK, 64'd0, any_seconds(), any_nanos());
    send_beat(MODE_TICK, 64'd1_500_000_000, '1, '1);
    send_beat(MODE_SPARE, any_count(), any_seconds(), any_nanos());
  endtask

  task automatic test_set_rules();
    logic [63:0] cs;
    program_regs(32'd3, 32'd131072, 32'd1, 32'd10);
    send_beat(MODE_TICK, 64'd2_000_000_000, any_seconds(), any_nanos());
    send_set_at(virtual_ns());
    send_set_at(virtual_ns() - 64'd1);
    send_set_at(virtual_ns() + 64'd2_000_000_005);
    // nanoseconds beyond one second, same whole second
    cs = virtual_ns() / SEC_NS;
    send_beat(MODE_SET, any_count(), cs[TSEC_W-1:0], '1);
    send_beat(MODE_SET, any_count(), '1, 30'd999_999_999);
  endtask

  task automatic test_register_extremes();
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_beat(MODE_TICK, 64'd0, any_seconds(), any_nanos());
    send_set_at(virtual_ns() + 64'd750);
    // zero ns per instruction pins the time at zero
    program_regs(32'hABCD_0000, 32'd1, 32'd0, 32'hFFFF_FFFF);
    send_beat(MODE_READ, any_count(), any_seconds(), any_nanos());
    send_set_at(64'd123_456_789);
    send_beat(MODE_TICK, 64'd0, any_seconds(), any_nanos());
    // zero drift holds the time at its ceiling
    program_regs(32'd1, 32'd0, 32'd1, 32'd10);
    send_beat(MODE_READ, any_count(), any_seconds(), any_nanos());
    send_beat(MODE_SET, any_count(), '1, 30'd0);
    program_regs(32'd65535, 32'd1, 32'd1, 32'd10);
    send_beat(MODE_READ, any_count(), any_seconds(), any_nanos());
  endtask

  task automatic random_beat();
    logic [63:0] t_now, delta, cs;
    int          pick;
    t_now = virtual_ns();
    cs    = t_now / SEC_NS;
    pick  = $urandom_range(0, 99);
    if (pick < 33) begin
      delta = (pick < 28) ? {32'd0, $urandom_range(1, 5_000_000)} : (any_count() >> 8);
      send_beat(MODE_TICK, base_count + delta, any_seconds(), any_nanos());
    end else if (pick < 53) begin
      send_beat(MODE_TICK, 64'd0, any_seconds(), any_nanos());
    end else if (pick < 57) begin
      delta = (base_count > 64'd1) ? 64'd1 + any_count() % (base_count - 64'd1) : any_count();
      send_beat(MODE_TICK, delta, any_seconds(), any_nanos());
    end else if (pick < 59) begin
      send_beat(MODE_TICK, any_count() >> $urandom_range(0, 63), any_seconds(), any_nanos());
    end else if (pick < 68) begin
      send_beat(MODE_READ, any_count(), any_seconds(), any_nanos());
    end else if (pick < 70) begin
      send_beat(MODE_SPARE, any_count(), any_seconds(), any_nanos());
    end else if (pick < 86) begin
      send_set_at(t_now + {32'd0, $urandom_range(1, 32'd3_000_000_000)});
    end else if (pick < 91) begin
      send_set_at(t_now);
    end else if (pick < 96) begin
      send_set_at(t_now - {32'd0, $urandom_range(1, 32'd2_000_000_000)});
    end else if (pick < 98) begin
      send_beat(MODE_SET, any_count(), any_seconds(), any_nanos());
    end else begin
      send_beat(MODE_SET, any_count(), cs[TSEC_W-1:0],
                TNS_W'(30'd1_000_000_000 + $urandom_range(0, 73_741_823)));
    end
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] w_npi, w_drift, w_step, w_limit;
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 7))
        0:       w_npi = $urandom;
        1:       w_npi = 32'd65535;
        2:       w_npi = 32'd1;
        default: w_npi = $urandom_range(1, 2000);
      endcase
      case ($urandom_range(0, 7))
        0:       w_drift = $urandom;
        1:       w_drift = $urandom_range(1, 255);
        2:       w_drift = 32'hFFFF_FFFF;
        default: w_drift = $urandom_range(32768, 131072);
      endcase
      case ($urandom_range(0, 7))
        0:       w_step = $urandom;
        1:       w_step = 32'd0;
        default: w_step = $urandom_range(1, 100_000);
      endcase
      case ($urandom_range(0, 7))
        0:       w_limit = 32'd0;
        1:       w_limit = $urandom;
        default: w_limit = $urandom_range(1, 40);
      endcase
      program_regs(w_npi, w_drift, w_step, w_limit);
      repeat (PHASE_BEATS) random_beat();
    end
  endtask

  // the top count locks every later count out, so it comes last
  task automatic test_count_ceiling();
    send_beat(MODE_TICK, '1, any_seconds(), any_nanos());
    send_beat(MODE_TICK, 64'd0, any_seconds(), any_nanos());
    send_beat(MODE_TICK, 64'd1, any_seconds(), any_nanos());
    send_beat(MODE_READ, any_count(), any_seconds(), any_nanos());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_tick_rules();
    test_set_rules();
    test_register_extremes();
    test_random_traffic();
    test_count_ceiling();
    s_axis_tvalid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d beats sent under %0d register settings, %0d results checked, %0d bad",
             beats_sent, reg_settings, results_seen, failures);
    $display("covered ticks, unknown runs, backward counts, reads, and sets ahead, level, behind");
    if (failures == 0 && pending_times.size() == 0) begin
      $display("virtual_instruction_clock: match");
    end else begin
      $display("virtual_instruction_clock: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/vic_pkg.sv
rtl/vic_serial_mul.sv
rtl/vic_serial_div.sv
rtl/virtual_instruction_clock.sv
rtl/vic_checker.sv
dv/virtual_instruction_clock_tb.sv
